// ----- design/bqr_pkg.sv -----
`timescale 1ns / 1ps
// shared types, codes and bf16 helpers for the query projection block
package bqr_pkg;

    localparam logic [1:0] MODE_LOAD_RANK   = 2'd0;
    localparam logic [1:0] MODE_LOAD_HIDDEN = 2'd1;
    localparam logic [1:0] MODE_QUERY       = 2'd2;
    localparam logic [1:0] MODE_HEAD        = 2'd3;

    localparam logic RESULT_QUERY = 1'b0;
    localparam logic RESULT_HEAD  = 1'b1;

    // 1/sqrt(8192) in float32
    localparam logic [31:0] HEAD_SCALE_BITS = 32'h3C3504F3;
    localparam logic [31:0] DEFAULT_NAN     = 32'hFFC00000;
    localparam logic [30:0] F32_INF_MAG     = 31'h7F800000;
    localparam logic [31:0] F32_QUIET_BIT   = 32'h00400000;

    typedef struct packed {
        logic [1:0]  mode;
        logic [11:0] element_index;
        logic [15:0] operand_value;
        logic        end_of_dot;
        logic [31:0] cosine_bits;
        logic [31:0] sine_bits;
    } t_request;

    typedef struct packed {
        logic        result_kind;
        logic [6:0]  column;
        logic [31:0] result_bits;
        logic        last_of_run;
    } t_result;

    typedef enum logic [1:0] {
        FP_MUL,
        FP_ADD,
        FP_SUB
    } t_fp_op;

    typedef struct packed {
        logic        start;
        t_fp_op      op;
        logic [31:0] a;
        logic [31:0] b;
    } t_fp_req;

    // unrounded value: mant * 2^(exp - 174), bit 47 weighs 2^(exp - 127)
    typedef struct packed {
        logic               special;
        logic [31:0]        spec_bits;
        logic               sign;
        logic signed [10:0] exp;
        logic [47:0]        mant;
    } t_fp_raw;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_MUL_WAIT,
        S_ADD,
        S_ADD_WAIT,
        S_FINISH,
        S_HEAD_WAIT,
        S_ROPE,
        S_ROPE_WAIT,
        S_EMIT_ODD
    } t_seq_state;

    function automatic logic [15:0] bf16_round(input logic [31:0] u);
        logic [31:0] s;
        s = u + 32'h00007FFF + {31'b0, u[16]};
        if (u[30:23] == 8'hFF && u[22:0] != 23'b0) begin
            return u[31:16] | 16'h0040;
        end
        return s[31:16];
    endfunction

endpackage

// ----- design/bqr_store.sv -----
`timescale 1ns / 1ps
// single-port bf16 vector store with registered read
module bqr_store
    import bqr_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_we,
    input  logic        i_re,
    input  logic [11:0] i_index,
    input  logic [15:0] i_wdata,
    output logic [15:0] o_rdata
);

    localparam int AW = $clog2(DEPTH);

    logic [15:0]   mem [DEPTH];
    logic [AW-1:0] addr;
    logic          in_range;

    assign addr     = AW'(i_index);
    assign in_range = 14'(i_index) < 14'(DEPTH);

    always_ff @(posedge i_clk) begin
        if (i_we && in_range) begin
            mem[addr] <= i_wdata;
        end
        if (i_re && in_range) begin
            o_rdata <= mem[addr];
        end
    end

endmodule

// ----- design/bqr_fpu.sv -----
`timescale 1ns / 1ps
// three-stage float32 multiply / add / subtract unit, round to nearest even
module bqr_fpu
    import bqr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_fp_req     i_req,
    output logic        o_done,
    output logic [31:0] o_result
);

    t_fp_raw raw1, r_raw1, raw2, r_raw2;
    logic    r_v1, r_v2, r_v3;
    logic [31:0] r_res;

    // stage 1: specials, exact product or aligned sum
    always_comb begin
        logic        sa, sb, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
        logic [31:0] bb, x, y;
        logic [23:0] ma, mb;
        logic [7:0]  exa, exb, d;
        logic [95:0] sh;
        logic [47:0] xm, ym;
        logic        sticky;
        raw1   = '0;
        bb     = i_req.b;
        b_nan  = bb[30:23] == 8'hFF && bb[22:0] != 23'b0;
        if (i_req.op == FP_SUB && !b_nan) begin
            bb[31] = ~bb[31];
        end
        sa     = i_req.a[31];
        sb     = bb[31];
        a_nan  = i_req.a[30:23] == 8'hFF && i_req.a[22:0] != 23'b0;
        a_inf  = i_req.a[30:0] == F32_INF_MAG;
        b_inf  = bb[30:0] == F32_INF_MAG;
        a_zero = i_req.a[30:0] == 31'b0;
        b_zero = bb[30:0] == 31'b0;
        x      = i_req.a;
        y      = bb;
        d      = 8'b0;
        sh     = '0;
        xm     = '0;
        ym     = '0;
        sticky = 1'b0;
        ma     = {i_req.a[30:23] != 8'b0, i_req.a[22:0]};
        mb     = {bb[30:23] != 8'b0, bb[22:0]};
        exa    = (i_req.a[30:23] == 8'b0) ? 8'd1 : i_req.a[30:23];
        exb    = (bb[30:23] == 8'b0) ? 8'd1 : bb[30:23];
        if (a_nan) begin
            raw1.special   = 1'b1;
            raw1.spec_bits = i_req.a | F32_QUIET_BIT;
        end else if (b_nan) begin
            raw1.special   = 1'b1;
            raw1.spec_bits = bb | F32_QUIET_BIT;
        end else if (i_req.op == FP_MUL) begin
            if (a_inf || b_inf) begin
                raw1.special   = 1'b1;
                raw1.spec_bits = ((a_inf && b_zero) || (b_inf && a_zero)) ?
                                 DEFAULT_NAN : {sa ^ sb, F32_INF_MAG};
            end else if (a_zero || b_zero) begin
                raw1.special   = 1'b1;
                raw1.spec_bits = {sa ^ sb, 31'b0};
            end else begin
                raw1.sign = sa ^ sb;
                raw1.exp  = 11'($signed({3'b0, exa}) + $signed({3'b0, exb})) - 11'sd126;
                raw1.mant = 48'(ma) * 48'(mb);
            end
        end else begin
            if (a_inf && b_inf && (sa != sb)) begin
                raw1.special   = 1'b1;
                raw1.spec_bits = DEFAULT_NAN;
            end else if (a_inf) begin
                raw1.special   = 1'b1;
                raw1.spec_bits = i_req.a;
            end else if (b_inf) begin
                raw1.special   = 1'b1;
                raw1.spec_bits = bb;
            end else begin
                // larger magnitude goes first
                if (i_req.a[30:0] < bb[30:0]) begin
                    x = bb;
                    y = i_req.a;
                    d = exb - exa;
                    xm = {1'b0, mb, 23'b0};
                    sh = {1'b0, ma, 23'b0, 48'b0} >> d;
                    raw1.exp = 11'(exb) + 11'sd1;
                end else begin
                    d = exa - exb;
                    xm = {1'b0, ma, 23'b0};
                    sh = {1'b0, mb, 23'b0, 48'b0} >> d;
                    raw1.exp = 11'(exa) + 11'sd1;
                end
                sticky = |sh[47:0];
                ym     = sh[95:48] | {47'b0, sticky};
                raw1.mant = (x[31] ^ y[31]) ? xm - ym : xm + ym;
                raw1.sign = (raw1.mant == 48'b0) ? (x[31] & y[31]) : x[31];
            end
        end
    end

    // stage 2: normalise, or denormalise below the smallest exponent
    always_comb begin
        logic [5:0]  lz;
        logic [10:0] rs;
        logic        st;
        raw2 = r_raw1;
        lz   = 6'd0;
        rs   = 11'd0;
        st   = 1'b0;
        for (int i = 0; i < 48; i++) begin
            if (r_raw1.mant[i]) begin
                lz = 6'(47 - i);
            end
        end
        if (r_raw1.exp > $signed({5'b0, lz})) begin
            raw2.mant = r_raw1.mant << lz;
            raw2.exp  = r_raw1.exp - $signed({5'b0, lz});
        end else if (r_raw1.exp >= 11'sd1) begin
            raw2.mant = r_raw1.mant << 6'(r_raw1.exp - 11'sd1);
            raw2.exp  = 11'sd1;
        end else begin
            rs = 11'(11'sd1 - r_raw1.exp);
            if (rs >= 11'd48) begin
                raw2.mant = {47'b0, |r_raw1.mant};
            end else begin
                st = |(r_raw1.mant & ~(48'hFFFFFFFFFFFF << rs[5:0]));
                raw2.mant = (r_raw1.mant >> rs[5:0]) | {47'b0, st};
            end
            raw2.exp = 11'sd1;
        end
    end

    always_ff @(posedge i_clk) begin
        logic        rnd;
        logic [35:0] pk;
        rnd = r_raw2.mant[23] & ((|r_raw2.mant[22:0]) | r_raw2.mant[24]);
        pk  = (36'(r_raw2.exp - 11'sd1) << 23) + 36'(r_raw2.mant[47:24]) + 36'(rnd);
        r_raw1 <= raw1;
        r_raw2 <= raw2;
        if (r_raw2.special) begin
            r_res <= r_raw2.spec_bits;
        end else if (r_raw2.mant == 48'b0) begin
            r_res <= {r_raw2.sign, 31'b0};
        end else if (pk >= 36'(F32_INF_MAG)) begin
            r_res <= {r_raw2.sign, F32_INF_MAG};
        end else begin
            r_res <= {r_raw2.sign, pk[30:0]};
        end
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_req.start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_done   = r_v3;
    assign o_result = r_res;

endmodule

// ----- design/bf16_query_rope_projection.sv -----
`timescale 1ns / 1ps
// top level: vector stores, dot-product sequencer, rotary pair and head scaling
//
//  channel   handshake                 payload
//  request   start in, busy out        i_request (t_request)
//  result    o_result_valid strobe     o_result (t_result)
//
// a load is taken while idle and leaves busy low
// a weight takes a store read, then a multiply and an add through the shared
// three-stage float unit; the final weight of a dot adds a finish step, a head
// scaling multiply for a head dot, and the rotary multiplies, difference and sum for an odd rotary column
// reset clears the sequencer, accumulator, column count and held even value
// results are strobed for one cycle and cannot be held off
module bf16_query_rope_projection
    import bqr_pkg::*;
#(
    parameter int RANK_LEN   = 1024,
    parameter int HIDDEN_LEN = 4096,
    parameter int HEAD_DIM   = 128,
    parameter int ROPE_DIM   = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_request i_request,
    output logic     busy,
    output logic     o_result_valid,
    output t_result  o_result
);

    localparam int CW         = $clog2(HEAD_DIM);
    localparam int ROPE_START = (ROPE_DIM >= HEAD_DIM) ? 0 : HEAD_DIM - ROPE_DIM;
    localparam logic ROPE_PAR = 1'(ROPE_START % 2);

    t_seq_state r_state, n_state;
    t_request   r_req, n_req;
    logic [31:0] r_acc, n_acc;
    logic [CW-1:0] r_col, n_col, r_cur, n_cur;
    logic [15:0] r_held, n_held, r_q, n_q;
    logic [31:0] r_t [4];
    logic [31:0] n_t [4];
    logic [2:0]  r_step, n_step;
    t_result     r_out, n_out;
    logic        r_out_valid, n_out_valid;

    logic        accept, in_range;
    logic [15:0] rank_data, hidden_data, stored;
    t_fp_req     fp_req;
    logic        fp_done;
    logic [31:0] fp_res;
    logic [15:0] q_now;

    assign accept = start && !busy;
    assign busy   = r_state != S_IDLE;

    // weight index inside the store that its mode names
    assign in_range = (i_request.mode == MODE_QUERY) ?
                      (14'(i_request.element_index) < 14'(RANK_LEN)) :
                      (14'(i_request.element_index) < 14'(HIDDEN_LEN));

    bqr_store #(.DEPTH(RANK_LEN)) u_rank (
        .i_clk   (i_clk),
        .i_we    (accept && i_request.mode == MODE_LOAD_RANK),
        .i_re    (accept),
        .i_index (i_request.element_index),
        .i_wdata (i_request.operand_value),
        .o_rdata (rank_data)
    );

    bqr_store #(.DEPTH(HIDDEN_LEN)) u_hidden (
        .i_clk   (i_clk),
        .i_we    (accept && i_request.mode == MODE_LOAD_HIDDEN),
        .i_re    (accept),
        .i_index (i_request.element_index),
        .i_wdata (i_request.operand_value),
        .o_rdata (hidden_data)
    );

    bqr_fpu u_fpu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (fp_req),
        .o_done   (fp_done),
        .o_result (fp_res)
    );

    assign stored = (r_req.mode == MODE_QUERY) ? rank_data : hidden_data;
    assign q_now  = bf16_round(r_acc);

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_cur  <= n_cur;
        r_q    <= n_q;
        r_t    <= n_t;
        r_step <= n_step;
        r_out  <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc       <= 32'b0;
            r_col       <= '0;
            r_held      <= 16'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_col       <= n_col;
            r_held      <= n_held;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_acc       = r_acc;
        n_col       = r_col;
        n_cur       = r_cur;
        n_held      = r_held;
        n_q         = r_q;
        n_t         = r_t;
        n_step      = r_step;
        n_out       = r_out;
        n_out_valid = 1'b0;
        fp_req      = '{start: 1'b0, op: FP_MUL, a: 32'b0, b: 32'b0};

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_req = i_request;
                    if (i_request.mode == MODE_QUERY || i_request.mode == MODE_HEAD) begin
                        if (in_range) begin
                            n_state = S_MUL;
                        end else if (i_request.end_of_dot) begin
                            n_state = S_FINISH;
                        end
                    end
                end
            end
            S_MUL: begin
                fp_req  = '{start: 1'b1, op: FP_MUL, a: {stored, 16'b0},
                            b: {r_req.operand_value, 16'b0}};
                n_state = S_MUL_WAIT;
            end
            S_MUL_WAIT: begin
                if (fp_done) begin
                    n_t[0]  = fp_res;
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                fp_req  = '{start: 1'b1, op: FP_ADD, a: r_acc, b: r_t[0]};
                n_state = S_ADD_WAIT;
            end
            S_ADD_WAIT: begin
                if (fp_done) begin
                    n_acc   = fp_res;
                    n_state = r_req.end_of_dot ? S_FINISH : S_IDLE;
                end
            end
            S_FINISH: begin
                n_acc = 32'b0;
                if (r_req.mode == MODE_HEAD) begin
                    fp_req  = '{start: 1'b1, op: FP_MUL, a: r_acc, b: HEAD_SCALE_BITS};
                    n_state = S_HEAD_WAIT;
                end else begin
                    n_cur = r_col;
                    // column count wraps at the head width
                    n_col = ({1'b0, r_col} + (CW+1)'(1) >= (CW+1)'(HEAD_DIM)) ?
                            '0 : r_col + CW'(1);
                    if ({1'b0, r_col} < (CW+1)'(ROPE_START)) begin
                        n_out       = '{result_kind: RESULT_QUERY, column: 7'(r_col),
                                        result_bits: {16'b0, q_now}, last_of_run: 1'b1};
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end else if ((r_col[0] ^ ROPE_PAR) == 1'b0) begin
                        // even rotary column waits for its partner
                        n_held  = q_now;
                        n_state = S_IDLE;
                    end else begin
                        n_q     = q_now;
                        n_step  = 3'd0;
                        n_state = S_ROPE;
                    end
                end
            end
            S_HEAD_WAIT: begin
                if (fp_done) begin
                    n_out       = '{result_kind: RESULT_HEAD, column: 7'b0,
                                    result_bits: fp_res, last_of_run: 1'b1};
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_ROPE: begin
                // x*c, y*s, y*c, x*s, then xc - ys and yc + xs
                fp_req.start = 1'b1;
                case (r_step)
                    3'd0:    fp_req = '{1'b1, FP_MUL, {r_held, 16'b0}, r_req.cosine_bits};
                    3'd1:    fp_req = '{1'b1, FP_MUL, {r_q, 16'b0}, r_req.sine_bits};
                    3'd2:    fp_req = '{1'b1, FP_MUL, {r_q, 16'b0}, r_req.cosine_bits};
                    3'd3:    fp_req = '{1'b1, FP_MUL, {r_held, 16'b0}, r_req.sine_bits};
                    3'd4:    fp_req = '{1'b1, FP_SUB, r_t[0], r_t[1]};
                    default: fp_req = '{1'b1, FP_ADD, r_t[2], r_t[3]};
                endcase
                n_state = S_ROPE_WAIT;
            end
            S_ROPE_WAIT: begin
                if (fp_done) begin
                    n_t[r_step[1:0]] = fp_res;
                    if (r_step == 3'd5) begin
                        n_out       = '{result_kind: RESULT_QUERY,
                                        column: 7'(r_cur - CW'(1)),
                                        result_bits: {16'b0, bf16_round(r_t[0])},
                                        last_of_run: 1'b0};
                        n_out_valid = 1'b1;
                        n_state     = S_EMIT_ODD;
                    end else begin
                        n_step  = r_step + 3'd1;
                        n_state = S_ROPE;
                    end
                end
            end
            S_EMIT_ODD: begin
                n_out       = '{result_kind: RESULT_QUERY, column: 7'(r_cur),
                                result_bits: {16'b0, bf16_round(r_t[1])}, last_of_run: 1'b1};
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

endmodule

// ----- verif/tb_bf16_query_rope_projection.sv -----
`timescale 1ns / 1ps
// testbench: directed and random requests against a bit-exact float32 predictor
module tb_bf16_query_rope_projection;
    import bqr_pkg::*;

    localparam int RANK_N     = 1024;
    localparam int HIDDEN_N   = 4096;
    localparam int ROPE_FIRST = 64;
    localparam int ITEM_GOAL  = 950;
    localparam int CYCLE_CAP  = 400000;
    localparam int QUIET_TAIL = 120;

    // predictor plus queue of expected results
    class proj_scoreboard;
        logic [15:0] rank_mem [RANK_N];
        logic [15:0] hid_mem [HIDDEN_N];
        logic [31:0] acc;
        logic [6:0]  col_cnt;
        logic [15:0] held_even;
        t_result     pending [$];
        int          errors;

        function new();
            acc = 32'h0;
            col_cnt = '0;
            held_even = '0;
            errors = 0;
            foreach (rank_mem[i]) rank_mem[i] = '0;
            foreach (hid_mem[i]) hid_mem[i] = '0;
        endfunction

        function automatic bit is_nan(logic [31:0] x);
            return x[30:23] == 8'hFF && x[22:0] != 0;
        endfunction

        function automatic bit is_inf(logic [31:0] x);
            return x[30:0] == F32_INF_MAG;
        endfunction

        // value = m * 2^e, rounded to nearest even
        function automatic logic [31:0] pack_f32(bit sgn, int e, logic [127:0] m);
            int p, bexp, sh;
            logic [127:0] q, rem, half;
            longint mag;
            p = 0;
            for (int i = 127; i >= 0; i--) begin
                if (m[i]) begin
                    p = i;
                    break;
                end
            end
            bexp = p + e + 127;
            sh = (bexp >= 1) ? p - 23 : p - 23 + (1 - bexp);
            if (sh <= 0) begin
                q = m << (-sh);
            end else if (sh > 100) begin
                q = '0;
            end else begin
                q = m >> sh;
                rem = m & ((128'd1 << sh) - 1);
                half = 128'd1 << (sh - 1);
                if (rem > half || (rem == half && q[0])) q = q + 1;
            end
            mag = (bexp >= 1) ? (longint'(bexp - 1) << 23) + longint'(q[63:0])
                              : longint'(q[63:0]);
            if (mag >= 64'h7F800000) mag = 64'h7F800000;
            return {sgn, mag[30:0]};
        endfunction

        function automatic void unpack_f32(logic [31:0] x, output int e,
                                           output logic [127:0] m);
            if (x[30:23] == 0) begin
                m = {105'b0, x[22:0]};
                e = -149;
            end else begin
                m = {104'b0, 1'b1, x[22:0]};
                e = int'(x[30:23]) - 150;
            end
        endfunction

        function automatic logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
            int ea, eb;
            logic [127:0] ma, mb;
            bit sg;
            sg = a[31] ^ b[31];
            if (is_nan(a)) return a | F32_QUIET_BIT;
            if (is_nan(b)) return b | F32_QUIET_BIT;
            if (is_inf(a) || is_inf(b)) begin
                if (a[30:0] == 0 || b[30:0] == 0) return DEFAULT_NAN;
                return {sg, F32_INF_MAG};
            end
            if (a[30:0] == 0 || b[30:0] == 0) return {sg, 31'b0};
            unpack_f32(a, ea, ma);
            unpack_f32(b, eb, mb);
            return pack_f32(sg, ea + eb, ma * mb);
        endfunction

        function automatic logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
            int ea, eb, d, tmp;
            logic [127:0] ma, mb, mt, big;
            bit sa, sb, st;
            if (is_nan(a)) return a | F32_QUIET_BIT;
            if (is_nan(b)) return b | F32_QUIET_BIT;
            if (is_inf(a) && is_inf(b) && a[31] != b[31]) return DEFAULT_NAN;
            if (is_inf(a)) return a;
            if (is_inf(b)) return b;
            if (a[30:0] == 0 && b[30:0] == 0) return (a[31] && b[31]) ? a : 32'h0;
            if (a[30:0] == 0) return b;
            if (b[30:0] == 0) return a;
            unpack_f32(a, ea, ma);
            unpack_f32(b, eb, mb);
            sa = a[31];
            sb = b[31];
            if (ea < eb) begin
                tmp = ea; ea = eb; eb = tmp;
                mt = ma; ma = mb; mb = mt;
                st = sa; sa = sb; sb = st;
            end
            d = ea - eb;
            // far smaller operand collapses to a sticky bit
            if (d > 60) begin
                d = 60;
                mb = 128'd1;
            end
            big = ma << d;
            if (sa == sb) return pack_f32(sa, ea - d, big + mb);
            if (big > mb) return pack_f32(sa, ea - d, big - mb);
            if (big < mb) return pack_f32(sb, ea - d, mb - big);
            return 32'h0;
        endfunction

        function automatic logic [31:0] fsub(logic [31:0] a, logic [31:0] b);
            if (is_nan(a)) return a | F32_QUIET_BIT;
            if (is_nan(b)) return b | F32_QUIET_BIT;
            return fadd(a, {~b[31], b[30:0]});
        endfunction

        function automatic logic [15:0] to_bf16(logic [31:0] u);
            logic [31:0] s;
            if (is_nan(u)) return u[31:16] | 16'h0040;
            s = u + 32'h7FFF + u[16];
            return s[31:16];
        endfunction

        function automatic void push_result(bit kind, logic [6:0] col,
                                            logic [31:0] bits, bit last);
            t_result r;
            r.result_kind = kind;
            r.column = col;
            r.result_bits = bits;
            r.last_of_run = last;
            pending.push_back(r);
        endfunction

        // one accepted request
        function void note_request(t_request rq);
            logic [31:0] sum, x, y, xc, ys, yc, xs;
            logic [15:0] qv, stored;
            logic [6:0]  col;
            case (rq.mode)
                MODE_LOAD_RANK: begin
                    if (rq.element_index < RANK_N) rank_mem[rq.element_index] = rq.operand_value;
                end
                MODE_LOAD_HIDDEN: begin
                    if (rq.element_index < HIDDEN_N)
                        hid_mem[rq.element_index] = rq.operand_value;
                end
                default: begin
                    if (rq.mode == MODE_QUERY ? rq.element_index < RANK_N
                                              : rq.element_index < HIDDEN_N) begin
                        stored = (rq.mode == MODE_QUERY) ? rank_mem[rq.element_index]
                                                         : hid_mem[rq.element_index];
                        acc = fadd(acc, fmul({stored, 16'h0}, {rq.operand_value, 16'h0}));
                    end
                    if (rq.end_of_dot) begin
                        sum = acc;
                        acc = 32'h0;
                        if (rq.mode == MODE_HEAD) begin
                            push_result(RESULT_HEAD, 7'd0, fmul(sum, HEAD_SCALE_BITS), 1'b1);
                        end else begin
                            col = col_cnt;
                            qv = to_bf16(sum);
                            col_cnt = col_cnt + 1;
                            if (col < ROPE_FIRST) begin
                                push_result(RESULT_QUERY, col, {16'h0, qv}, 1'b1);
                            end else if (((col - ROPE_FIRST) & 1) == 0) begin
                                held_even = qv;
                            end else begin
                                x = {held_even, 16'h0};
                                y = {qv, 16'h0};
                                xc = fmul(x, rq.cosine_bits);
                                ys = fmul(y, rq.sine_bits);
                                yc = fmul(y, rq.cosine_bits);
                                xs = fmul(x, rq.sine_bits);
                                push_result(RESULT_QUERY, col - 7'd1,
                                            {16'h0, to_bf16(fsub(xc, ys))}, 1'b0);
                                push_result(RESULT_QUERY, col,
                                            {16'h0, to_bf16(fadd(yc, xs))}, 1'b1);
                            end
                        end
                    end
                end
            endcase
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $realtime, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.result_kind !== want.result_kind)
                $display("%0t: result_kind expected %h actual %h", $realtime,
                         want.result_kind, got.result_kind);
            if (got.column !== want.column)
                $display("%0t: column expected %h actual %h", $realtime,
                         want.column, got.column);
            if (got.result_bits !== want.result_bits)
                $display("%0t: result_bits expected %h actual %h", $realtime,
                         want.result_bits, got.result_bits);
            if (got.last_of_run !== want.last_of_run)
                $display("%0t: last_of_run expected %h actual %h", $realtime,
                         want.last_of_run, got.last_of_run);
            if (got !== want) errors++;
        endfunction
    endclass

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    t_request i_request;
    logic     busy;
    logic     o_result_valid;
    t_result  o_result;

    proj_scoreboard sb;
    int  cycles = 0;
    int  sent;
    bit  quiet;
    bit  rank_seen [RANK_N];
    bit  hid_seen [HIDDEN_N];
    int  rank_list [$];
    int  hid_list [$];

    bf16_query_rope_projection dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_request      (i_request),
        .busy           (busy),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // watchdog on total run length
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // results cannot be held off, so every strobe is checked at once
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) sb.check_result(o_result);
    end

    // bf16 with a moderate exponent most of the time, otherwise any pattern
    function automatic logic [15:0] rand_bf16();
        if ($urandom_range(0, 3) != 0)
            return {1'($urandom), 8'($urandom_range(110, 140)), 7'($urandom)};
        return 16'($urandom);
    endfunction

    function automatic logic [31:0] rand_trig();
        if ($urandom_range(0, 7) != 0)
            return {1'($urandom), 8'($urandom_range(118, 127)), 23'($urandom)};
        return $urandom;
    endfunction

    // hold one request until it is taken
    task automatic send(logic [1:0] mode, logic [11:0] idx, logic [15:0] val, bit eod);
        t_request rq;
        @(negedge i_clk);
        rq.mode = mode;
        rq.element_index = idx;
        rq.operand_value = val;
        rq.end_of_dot = eod;
        rq.cosine_bits = rand_trig();
        rq.sine_bits = rand_trig();
        i_request <= rq;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_request(i_request);
        sent++;
        if (mode == MODE_LOAD_RANK && idx < RANK_N && !rank_seen[idx]) begin
            rank_seen[idx] = 1'b1;
            rank_list.push_back(idx);
        end
        if (mode == MODE_LOAD_HIDDEN && !hid_seen[idx]) begin
            hid_seen[idx] = 1'b1;
            hid_list.push_back(idx);
        end
        // random idle burst after a request
        if (!quiet && $urandom_range(0, 4) == 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat ($urandom_range(0, 2)) @(negedge i_clk);
        end
    endtask

    // a weight index that never reads an unwritten entry
    function automatic logic [11:0] pick_index(logic [1:0] mode);
        if (mode == MODE_QUERY) begin
            if ($urandom_range(0, 15) == 0) return 12'($urandom_range(RANK_N, 4095));
            return 12'(rank_list[$urandom_range(0, rank_list.size() - 1)]);
        end
        return 12'(hid_list[$urandom_range(0, hid_list.size() - 1)]);
    endfunction

    task automatic dot_run(logic [1:0] mode, int n, bit mixed);
        logic [1:0] m;
        for (int i = 0; i < n; i++) begin
            m = (mixed && $urandom_range(0, 1)) ? (mode ^ 2'b01) : mode;
            if (i == n - 1) m = mode;
            send(m, pick_index(m), rand_bf16(), i == n - 1);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        // even rope columns finish with no result
        repeat (60) @(posedge i_clk);
    endtask

    initial begin
        sb = new();
        sent = 0;
        quiet = 1'b0;
        start = 1'b0;
        i_request = '0;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: store extremes, ignored loads, beyond-store weight
        send(MODE_LOAD_RANK, 12'd0, 16'h3F80, 1'b1);
        send(MODE_LOAD_RANK, 12'd1023, 16'hFFFF, 1'b0);
        send(MODE_LOAD_RANK, 12'd4095, 16'h0000, 1'b0);
        send(MODE_LOAD_RANK, 12'd5, 16'h7F7F, 1'b0);
        send(MODE_LOAD_RANK, 12'd6, 16'h8001, 1'b0);
        send(MODE_LOAD_HIDDEN, 12'd0, 16'h4000, 1'b0);
        send(MODE_LOAD_HIDDEN, 12'd4095, 16'h7F80, 1'b0);
        send(MODE_LOAD_HIDDEN, 12'd2730, 16'h0000, 1'b0);
        send(MODE_QUERY, 12'd0, 16'h3F80, 1'b1);
        send(MODE_QUERY, 12'd1023, 16'h3F80, 1'b1);
        send(MODE_QUERY, 12'd5, 16'h7F7F, 1'b0);
        send(MODE_QUERY, 12'd5, 16'h7F7F, 1'b1);
        send(MODE_QUERY, 12'd6, 16'h0001, 1'b1);
        send(MODE_QUERY, 12'd2048, 16'hFFFF, 1'b1);
        send(MODE_HEAD, 12'd0, 16'hC000, 1'b1);
        send(MODE_HEAD, 12'd4095, 16'h0000, 1'b1);
        send(MODE_QUERY, 12'd0, 16'h4040, 1'b0);
        send(MODE_HEAD, 12'd2730, 16'h3F80, 1'b1);
        send(MODE_HEAD, 12'd0, 16'h3F80, 1'b0);
        send(MODE_QUERY, 12'd0, 16'h3F80, 1'b1);
        drain();

        while (sent < ITEM_GOAL) begin
            if (sent > ITEM_GOAL - QUIET_TAIL) quiet = 1'b1;
            if (sent > 400 && sent < 410) drain();
            case ($urandom_range(0, 19))
                0, 1:
                    send(MODE_LOAD_RANK, 12'($urandom), rand_bf16(), 1'($urandom));
                2, 3:
                    send(MODE_LOAD_HIDDEN, 12'($urandom), rand_bf16(), 1'($urandom));
                4:
                    dot_run(($urandom_range(0, 1)) ? MODE_QUERY : MODE_HEAD,
                            $urandom_range(2, 3), 1'b1);
                5:
                    send(MODE_QUERY, pick_index(MODE_QUERY), rand_bf16(), 1'b0);
                6, 7, 8:
                    dot_run(MODE_HEAD, $urandom_range(1, 3), 1'b0);
                default:
                    dot_run(MODE_QUERY, $urandom_range(1, 3), 1'b0);
            endcase
        end
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- bf16_query_rope_projection.f -----
design/bqr_pkg.sv
design/bqr_store.sv
design/bqr_fpu.sv
design/bf16_query_rope_projection.sv
verif/tb_bf16_query_rope_projection.sv
